// File: design/ibps_pkg.sv
// Shared types and constants for the inner bremsstrahlung photon sampler.
// Used by the shared arithmetic unit and by the top level; no dependencies.
package ibps_pkg;

   // Fixed-point constants (Q8.24 unless noted).
   localparam logic [63:0] ONE_Q24      = 64'd16777216;
   localparam logic [63:0] TWO_Q24      = 64'd33554432;
   localparam logic [63:0] ONE_SQ_Q48   = 64'd281474976710656;
   localparam logic [63:0] C001_Q24     = 64'd167772;
   localparam logic [63:0] C002_Q24     = 64'd335544;
   localparam logic [63:0] ME_EV        = 64'd510999;
   localparam logic [63:0] LN2_Q32      = 64'd2977044472;
   localparam logic [63:0] ALPHA_PI_Q32 = 64'd9976433;

   localparam int POINT_COUNT_DEF = 100;

   // Right shifts applied after a multiply.
   localparam logic [5:0] SH_NONE = 6'd0;
   localparam logic [5:0] SH_BIAS = 6'd16;
   localparam logic [5:0] SH_Q24  = 6'd24;
   localparam logic [5:0] SH_STEP = 6'd25;
   localparam logic [5:0] SH_Q32  = 6'd32;

   // Register indexes of the CSR port.
   localparam logic CSR_IB_ENABLE = 1'b0;
   localparam logic CSR_BIAS      = 1'b1;

   localparam logic        IB_ENABLE_RST = 1'b1;
   localparam logic [31:0] BIAS_RST      = 32'd65536;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [5:0]  shift;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } alu_rsp_type;

endpackage

// File: design/ibps_alu.sv
// Shared multi-cycle arithmetic unit: 64x64 multiply with shift and saturation,
// 64-bit restoring divide and 64-bit integer square root. Depends on ibps_pkg.
module ibps_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  ibps_pkg::alu_req_type req,
   output ibps_pkg::alu_rsp_type rsp
);
   import ibps_pkg::*;

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_MFIN,
      A_DIV,
      A_SQRT
   } alu_state_type;

   alu_state_type state_ff;
   logic [5:0]    cnt_ff;
   logic [63:0]   a_ff;
   logic [63:0]   b_ff;
   logic [5:0]    shift_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   rem_ff;
   logic [63:0]   q_ff;
   logic [63:0]   root_ff;
   logic [63:0]   bit_ff;
   logic          done_ff;
   logic [63:0]   result_ff;

   logic [31:0]  mul_a;
   logic [31:0]  mul_b;
   logic [63:0]  prod;
   logic [127:0] part;
   logic [127:0] shifted;
   logic         ovf;
   logic [64:0]  div_r2;
   logic [64:0]  div_diff;
   logic         div_ge;
   logic [63:0]  div_q_in;
   logic [63:0]  sq_trial;
   logic         sq_ge;
   logic [63:0]  sq_root_in;

   // Partial products in the order low*low, low*high, high*low, high*high.
   always_comb begin
      mul_a    = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      mul_b    = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      prod     = {32'd0, mul_a} * {32'd0, mul_b};
      part     = {64'd0, prod} << {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0], 5'd0};
      shifted  = acc_ff >> shift_ff;
      ovf      = (acc_ff[127:64] >> shift_ff) != 64'd0;
      div_r2   = {rem_ff, q_ff[63]};
      div_diff = div_r2 - {1'b0, b_ff};
      div_ge   = div_r2 >= {1'b0, b_ff};
      div_q_in = {q_ff[62:0], div_ge};
      sq_trial = root_ff + bit_ff;
      sq_ge    = q_ff >= sq_trial;
      sq_root_in = sq_ge ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            A_IDLE: begin
               if (req.start) begin
                  a_ff     <= req.a;
                  b_ff     <= req.b;
                  shift_ff <= req.shift;
                  cnt_ff   <= '0;
                  unique case (req.op)
                     ALU_MUL: begin
                        acc_ff   <= '0;
                        state_ff <= A_MUL;
                     end
                     ALU_DIV: begin
                        q_ff     <= req.a;
                        rem_ff   <= '0;
                        state_ff <= A_DIV;
                     end
                     ALU_SQRT: begin
                        q_ff     <= req.a;
                        root_ff  <= '0;
                        bit_ff   <= 64'd1 << 62;
                        state_ff <= A_SQRT;
                     end
                     default: begin
                        result_ff <= '0;
                        done_ff   <= 1'b1;
                     end
                  endcase
               end
            end
            A_MUL: begin
               acc_ff <= acc_ff + part;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd3) begin
                  state_ff <= A_MFIN;
               end
            end
            A_MFIN: begin
               result_ff <= ovf ? '1 : shifted[63:0];
               done_ff   <= 1'b1;
               state_ff  <= A_IDLE;
            end
            A_DIV: begin
               rem_ff <= div_ge ? div_diff[63:0] : div_r2[63:0];
               q_ff   <= div_q_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  result_ff <= div_q_in;
                  done_ff   <= 1'b1;
                  state_ff  <= A_IDLE;
               end
            end
            A_SQRT: begin
               if (sq_ge) begin
                  q_ff <= q_ff - sq_trial;
               end
               root_ff <= sq_root_in;
               bit_ff  <= bit_ff >> 2;
               cnt_ff  <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) begin
                  result_ff <= sq_root_in;
                  done_ff   <= 1'b1;
                  state_ff  <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

// File: design/inner_brems_photon_sampler.sv
// Inner bremsstrahlung photon sampler, one request at a time through one shared unit.
// The work for a beta that radiates is done by the shared divider, square root and
// multiplier; a non-beta, disabled or low-energy request takes a shorter path. A new
// request is taken only once the previous answer is in the output register. Reset is
// synchronous and active high: it restores ib_enable and bias_factor; the scratch table
// is never cleared.
module inner_brems_photon_sampler #(
   parameter int POINT_COUNT = ibps_pkg::POINT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_is_beta,
   input  logic [23:0] req_kinetic_energy_ev,
   input  logic [31:0] req_rand_emit,
   input  logic [31:0] req_rand_energy,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_photon_emitted,
   output logic [23:0] rsp_photon_energy_ev,
   output logic [31:0] rsp_emit_probability,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ibps_pkg::*;

   localparam int IW = $clog2(POINT_COUNT);
   localparam logic [IW-1:0] LAST_IDX = IW'(POINT_COUNT - 1);
   localparam logic [63:0]   NPTS_64  = 64'(POINT_COUNT);

   // The sequencer walks one request through setup, the per-point spectrum
   // evaluation, the probability and the inverse CDF search. Every step that
   // needs arithmetic hands its operands to the shared unit and waits for done.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_WP,
      ST_DELTA,
      ST_WPWP,
      ST_PP,
      ST_PT_START,
      ST_PT_WW,
      ST_PT_P,
      ST_PT_DEN,
      ST_PT_A,
      ST_LN_NORM,
      ST_LN_SQ,
      ST_LN_MUL,
      ST_PT_S,
      ST_PT_DEN2,
      ST_PT_R,
      ST_PT_T,
      ST_PT_PHI,
      ST_PT_ACC,
      ST_PROB,
      ST_RD_TS,
      ST_THR,
      ST_SR_RD,
      ST_SR_CMP,
      ST_ENERGY,
      ST_OUT
   } state_type;

   state_type   state_ff;
   logic        issued_ff;
   alu_req_type alu_req_ff;
   alu_rsp_type alu_rsp;

   logic        ib_enable_ff;
   logic [31:0] bias_ff;

   logic [23:0] e_ff;
   logic [31:0] r1_ff;
   logic [31:0] r2_ff;
   logic [63:0] wp_ff;
   logic [63:0] wpwp_ff;
   logic [63:0] pp_ff;
   logic [63:0] delta_ff;
   logic [63:0] om_ff;
   logic [63:0] ww_ff;
   logic [63:0] p_ff;
   logic [63:0] a_ff;
   logic [63:0] y_ff;
   logic [63:0] lg_ff;
   logic [4:0]  k_ff;
   logic [63:0] br_ff;
   logic [63:0] tq_ff;
   logic [63:0] phi_ff;
   logic [63:0] prev_ff;
   logic [63:0] total_ff;
   logic [IW-1:0] idx_ff;
   logic [31:0] thr_ff;

   logic        out_emit_ff;
   logic [23:0] out_energy_ff;
   logic [31:0] out_prob_ff;

   logic        rsp_valid_ff;
   logic        rsp_emit_ff;
   logic [23:0] rsp_energy_ff;
   logic [31:0] rsp_prob_ff;

   // Scratch table of the running trapezoid integral, one entry per point.
   logic [31:0]   tbl_mem [POINT_COUNT];
   logic          tbl_we_ff;
   logic [IW-1:0] tbl_wa_ff;
   logic [31:0]   tbl_wd_ff;
   logic [31:0]   tbl_rd_ff;

   logic [63:0] w_val;
   logic [64:0] sum_val;
   logic [63:0] total_in;
   logic [31:0] total_sat;
   logic [31:0] prob_in;

   function automatic alu_req_type mk_req(input alu_op_type op, input logic [63:0] a,
                                          input logic [63:0] b, input logic [5:0] sh);
      alu_req_type r;
      r.start = 1'b1;
      r.op    = op;
      r.a     = a;
      r.b     = b;
      r.shift = sh;
      return r;
   endfunction

   ibps_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req_ff),
      .rsp   (alu_rsp)
   );

   // The electron energy at the current point and the integral with a new trapezoid.
   always_comb begin
      w_val     = wp_ff - om_ff;
      sum_val   = {1'b0, total_ff} + {1'b0, alu_rsp.result};
      total_in  = (idx_ff == '0) ? total_ff : (sum_val[64] ? '1 : sum_val[63:0]);
      total_sat = (total_in[63:32] != 32'd0) ? 32'hFFFF_FFFF : total_in[31:0];
      prob_in   = (alu_rsp.result[63:32] != 32'd0) ? 32'hFFFF_FFFF : alu_rsp.result[31:0];
   end

   // Configuration registers; the port never pushes back.
   always_ff @(posedge clock) begin
      if (reset) begin
         ib_enable_ff <= IB_ENABLE_RST;
         bias_ff      <= BIAS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IB_ENABLE: ib_enable_ff <= csr_wdata[0];
            CSR_BIAS:      bias_ff      <= csr_wdata;
            default:       ib_enable_ff <= ib_enable_ff;
         endcase
      end
   end

   // The table write is registered and lands in the cycle after the sequencer produces
   // the entry; the read port follows the point index.
   always_ff @(posedge clock) begin
      if (tbl_we_ff) begin
         tbl_mem[tbl_wa_ff] <= tbl_wd_ff;
      end
      tbl_rd_ff <= tbl_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      alu_req_ff.start <= 1'b0;
      tbl_we_ff        <= 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         state_ff         <= ST_IDLE;
         issued_ff        <= 1'b0;
         alu_req_ff.start <= 1'b0;
         tbl_we_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  e_ff          <= req_kinetic_energy_ev;
                  r1_ff         <= req_rand_emit;
                  r2_ff         <= req_rand_energy;
                  out_emit_ff   <= 1'b0;
                  out_energy_ff <= '0;
                  out_prob_ff   <= '0;
                  issued_ff     <= 1'b0;
                  if (!ib_enable_ff || !req_is_beta) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_WP;
                  end
               end
            end
            // W' - 1 = E * 2^24 / me.
            ST_WP: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_DIV, {16'd0, e_ff, 24'd0}, ME_EV, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  wp_ff     <= ONE_Q24 + alu_rsp.result;
                  om_ff     <= alu_rsp.result - C001_Q24;
                  if (alu_rsp.result <= C002_Q24) begin
                     state_ff <= ST_OUT;
                  end else begin
                     state_ff <= ST_DELTA;
                  end
               end
            end
            ST_DELTA: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_DIV, om_ff, NPTS_64, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  delta_ff  <= alu_rsp.result;
                  state_ff  <= ST_WPWP;
               end
            end
            ST_WPWP: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, wp_ff, wp_ff, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  wpwp_ff   <= alu_rsp.result;
                  state_ff  <= ST_PP;
               end
            end
            ST_PP: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_SQRT, wpwp_ff - ONE_SQ_Q48, '0, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  pp_ff     <= alu_rsp.result;
                  idx_ff    <= '0;
                  om_ff     <= C001_Q24;
                  total_ff  <= '0;
                  prev_ff   <= '0;
                  state_ff  <= ST_PT_START;
               end
            end
            ST_PT_START: begin
               if (om_ff >= wp_ff || w_val <= ONE_Q24) begin
                  phi_ff   <= '0;
                  state_ff <= ST_PT_ACC;
               end else begin
                  state_ff <= ST_PT_WW;
               end
            end
            ST_PT_WW: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, w_val, w_val, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  ww_ff     <= alu_rsp.result;
                  state_ff  <= ST_PT_P;
               end
            end
            ST_PT_P: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_SQRT, ww_ff - ONE_SQ_Q48, '0, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  p_ff      <= alu_rsp.result;
                  if (alu_rsp.result == '0 || pp_ff == '0) begin
                     phi_ff   <= '0;
                     state_ff <= ST_PT_ACC;
                  end else begin
                     state_ff <= ST_PT_DEN;
                  end
               end
            end
            ST_PT_DEN: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, wp_ff, p_ff, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  a_ff      <= alu_rsp.result;
                  if (alu_rsp.result == '0) begin
                     phi_ff   <= '0;
                     state_ff <= ST_PT_ACC;
                  end else begin
                     state_ff <= ST_PT_A;
                  end
               end
            end
            ST_PT_A: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_DIV, ww_ff + wpwp_ff, a_ff, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  a_ff      <= alu_rsp.result;
                  y_ff      <= w_val + p_ff;
                  lg_ff     <= '0;
                  state_ff  <= ST_LN_NORM;
               end
            end
            // Integer part of log2 by halving down below two.
            ST_LN_NORM: begin
               if (y_ff >= TWO_Q24) begin
                  y_ff  <= y_ff >> 1;
                  lg_ff <= lg_ff + ONE_Q24;
               end else begin
                  k_ff     <= 5'd23;
                  state_ff <= ST_LN_SQ;
               end
            end
            // One fraction bit of log2 per squaring.
            ST_LN_SQ: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, y_ff, y_ff, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  if (alu_rsp.result >= TWO_Q24) begin
                     y_ff  <= alu_rsp.result >> 1;
                     lg_ff <= lg_ff | (64'd1 << k_ff);
                  end else begin
                     y_ff <= alu_rsp.result;
                  end
                  if (k_ff == 5'd0) begin
                     state_ff <= ST_LN_MUL;
                  end else begin
                     k_ff <= k_ff - 5'd1;
                  end
               end
            end
            ST_LN_MUL: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, lg_ff, LN2_Q32, SH_Q32);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  y_ff      <= alu_rsp.result;
                  state_ff  <= ST_PT_S;
               end
            end
            ST_PT_S: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, a_ff, y_ff, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  br_ff     <= alu_rsp.result - TWO_Q24;
                  if (alu_rsp.result <= TWO_Q24) begin
                     phi_ff   <= '0;
                     state_ff <= ST_PT_ACC;
                  end else begin
                     state_ff <= ST_PT_DEN2;
                  end
               end
            end
            ST_PT_DEN2: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, om_ff, pp_ff, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  tq_ff     <= alu_rsp.result;
                  if (alu_rsp.result == '0) begin
                     phi_ff   <= '0;
                     state_ff <= ST_PT_ACC;
                  end else begin
                     state_ff <= ST_PT_R;
                  end
               end
            end
            ST_PT_R: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_DIV, {p_ff[31:0], 32'd0}, tq_ff, SH_NONE);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  tq_ff     <= alu_rsp.result;
                  state_ff  <= ST_PT_T;
               end
            end
            ST_PT_T: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, ALPHA_PI_Q32, tq_ff, SH_Q32);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  tq_ff     <= alu_rsp.result;
                  state_ff  <= ST_PT_PHI;
               end
            end
            ST_PT_PHI: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, tq_ff, br_ff, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  phi_ff    <= alu_rsp.result;
                  state_ff  <= ST_PT_ACC;
               end
            end
            // The first point only records a zero integral; later points add a
            // trapezoid of width delta.
            ST_PT_ACC: begin
               if (idx_ff != '0 && !issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, prev_ff + phi_ff, delta_ff, SH_STEP);
                  issued_ff  <= 1'b1;
               end else if (idx_ff == '0 || alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  total_ff  <= total_in;
                  tbl_we_ff <= 1'b1;
                  tbl_wa_ff <= idx_ff;
                  tbl_wd_ff <= total_sat;
                  prev_ff   <= phi_ff;
                  if (idx_ff == LAST_IDX) begin
                     state_ff <= ST_PROB;
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     om_ff    <= om_ff + delta_ff;
                     state_ff <= ST_PT_START;
                  end
               end
            end
            ST_PROB: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, total_ff, {32'd0, bias_ff}, SH_BIAS);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff   <= 1'b0;
                  out_prob_ff <= prob_in;
                  if (r1_ff >= prob_in) begin
                     state_ff <= ST_OUT;
                  end else begin
                     idx_ff   <= LAST_IDX;
                     state_ff <= ST_RD_TS;
                  end
               end
            end
            ST_RD_TS: begin
               state_ff <= ST_THR;
            end
            ST_THR: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, {32'd0, r2_ff}, {32'd0, tbl_rd_ff}, SH_Q32);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff <= 1'b0;
                  thr_ff    <= alu_rsp.result[31:0];
                  idx_ff    <= '0;
                  om_ff     <= C001_Q24;
                  state_ff  <= ST_SR_RD;
               end
            end
            ST_SR_RD: begin
               state_ff <= ST_SR_CMP;
            end
            // First point whose integral reaches the threshold, else the last one.
            ST_SR_CMP: begin
               if (thr_ff <= tbl_rd_ff || idx_ff == LAST_IDX) begin
                  state_ff <= ST_ENERGY;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  om_ff    <= om_ff + delta_ff;
                  state_ff <= ST_SR_RD;
               end
            end
            ST_ENERGY: begin
               if (!issued_ff) begin
                  alu_req_ff <= mk_req(ALU_MUL, om_ff, ME_EV, SH_Q24);
                  issued_ff  <= 1'b1;
               end else if (alu_rsp.done) begin
                  issued_ff     <= 1'b0;
                  out_emit_ff   <= 1'b1;
                  out_energy_ff <= alu_rsp.result[23:0];
                  state_ff      <= ST_OUT;
               end
            end
            // Hand the answer to the output register once it is free.
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_emit_ff   <= out_emit_ff;
                  rsp_energy_ff <= out_energy_ff;
                  rsp_prob_ff   <= out_prob_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_photon_emitted   = rsp_emit_ff;
   assign rsp_photon_energy_ev = rsp_energy_ff;
   assign rsp_emit_probability = rsp_prob_ff;

   // An emitted photon needs a nonzero probability.
   a_emit_prob : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_photon_emitted |-> rsp_emit_probability != 32'd0)
      else $error("photon emitted with zero probability");

   // No photon means no energy.
   a_no_emit_energy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_photon_emitted |-> rsp_photon_energy_ev == 24'd0)
      else $error("energy reported without a photon");

   // An accepted request occupies the block on the next cycle.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the sequencer stays idle");

   // The shared unit is never started twice in a row.
   a_alu_single : assert property (@(posedge clock) disable iff (reset)
      alu_req_ff.start |=> !alu_req_ff.start)
      else $error("shared unit started twice in a row");

endmodule

// File: tb/tb_ibps_checker.sv
`timescale 1ns / 1ps
// Checker for the inner bremsstrahlung photon sampler: predicts each response and compares it.
// Depends on ibps_pkg for constants and register indexes; watches the block's ports only.
module tb_ibps_checker #(
   parameter int POINT_COUNT = ibps_pkg::POINT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_is_beta,
   input  logic [23:0] req_kinetic_energy_ev,
   input  logic [31:0] req_rand_emit,
   input  logic [31:0] req_rand_energy,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_photon_emitted,
   input  logic [23:0] rsp_photon_energy_ev,
   input  logic [31:0] rsp_emit_probability,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);
   import ibps_pkg::*;

   typedef struct packed {
      logic        emitted;
      logic [23:0] energy_ev;
      logic [31:0] probability;
   } photon_result_type;

   photon_result_type expected_photons[$];
   logic           enable_copy;
   logic [31:0]    bias_copy;
   logic [31:0]    cdf_table[POINT_COUNT];

   function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> s;
      if (prod[127:64] != 0) return '1;
      return prod[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] nat_log(logic [63:0] x);
      logic [63:0] y, lg;
      y = x;
      lg = 0;
      if (x < ONE_Q24) return 0;
      while (y >= TWO_Q24) begin
         y = y >> 1;
         lg = lg + ONE_Q24;
      end
      for (int k = 23; k >= 0; k--) begin
         y = (y * y) >> 24;
         if (y >= TWO_Q24) begin
            y = y >> 1;
            lg[k] = 1'b1;
         end
      end
      return mul_shift(lg, LN2_Q32, 32);
   endfunction

   // Photon spectrum at total energy wp and photon energy om, Q.32.
   function automatic logic [63:0] spectrum_at(logic [63:0] wp, logic [63:0] om);
      logic [63:0] w, p, pp, num, den, a, s, r, br;
      if (om >= wp) return 0;
      w = wp - om;
      if (w <= ONE_Q24 || om == 0) return 0;
      p = int_sqrt(w * w - ONE_SQ_Q48);
      pp = int_sqrt(wp * wp - ONE_SQ_Q48);
      if (pp == 0 || p == 0) return 0;
      num = w * w + wp * wp;
      den = mul_shift(wp, p, 24);
      if (den == 0) return 0;
      a = num / den;
      s = mul_shift(a, nat_log(w + p), 24);
      if (s <= TWO_Q24) return 0;
      br = s - TWO_Q24;
      den = mul_shift(om, pp, 24);
      if (den == 0) return 0;
      r = (p << 32) / den;
      return mul_shift(mul_shift(ALPHA_PI_Q32, r, 32), br, 24);
   endfunction

   function automatic photon_result_type predict_photon(logic beta, logic [23:0] e_ev,
                                                     logic [31:0] r_emit, logic [31:0] r_energy);
      photon_result_type res;
      logic [63:0] wp, mo, delta, total, prev, phi, inc, prob, thr, om;
      int pick;
      res = '0;
      total = 0;
      prev = 0;
      if (!enable_copy || !beta) return res;
      wp = ONE_Q24 + (({40'd0, e_ev} << 24) / ME_EV);
      mo = wp - ONE_Q24;
      if (mo <= C002_Q24) return res;
      mo = mo - C001_Q24;
      delta = mo / POINT_COUNT;
      for (int i = 0; i < POINT_COUNT; i++) begin
         phi = spectrum_at(wp, C001_Q24 + i * delta);
         if (i > 0) begin
            inc = mul_shift(prev + phi, delta, 25);
            total = (total > ~inc) ? '1 : total + inc;
         end
         cdf_table[i] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
         prev = phi;
      end
      prob = mul_shift(total, {32'd0, bias_copy}, 16);
      if (prob > 64'hFFFF_FFFF) prob = 64'hFFFF_FFFF;
      res.probability = prob[31:0];
      if ({32'd0, r_emit} >= prob) return res;
      // Inverse CDF search; falls back to the last point.
      thr = mul_shift({32'd0, r_energy}, {32'd0, cdf_table[POINT_COUNT-1]}, 32);
      pick = POINT_COUNT - 1;
      for (int i = 0; i < POINT_COUNT; i++) begin
         if (thr <= {32'd0, cdf_table[i]}) begin
            pick = i;
            break;
         end
      end
      om = C001_Q24 + pick * delta;
      om = mul_shift(om, ME_EV, 24);
      res.emitted = 1'b1;
      res.energy_ev = om[23:0];
      return res;
   endfunction

   always @(posedge clock) begin
      photon_result_type exp_r;
      if (reset) begin
         expected_photons.delete();
         enable_copy = IB_ENABLE_RST;
         bias_copy = BIAS_RST;
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IB_ENABLE) enable_copy = csr_wdata[0];
            else bias_copy = csr_wdata;
         end
         if (req_valid && !req_stall)
            expected_photons.insert(expected_photons.size(),
                                    predict_photon(req_is_beta, req_kinetic_energy_ev,
                                                   req_rand_emit, req_rand_energy));
         if (rsp_valid && !rsp_stall) begin
            if (expected_photons.size() == 0) begin
               $error("unexpected response: emitted=%0d energy=%0d prob=%h",
                      rsp_photon_emitted, rsp_photon_energy_ev, rsp_emit_probability);
               fail_count++;
            end else begin
               exp_r = expected_photons.pop_front();
               if (rsp_photon_emitted !== exp_r.emitted) begin
                  $error("photon_emitted: expected %0d, got %0d",
                         exp_r.emitted, rsp_photon_emitted);
                  fail_count++;
               end
               if (rsp_photon_energy_ev !== exp_r.energy_ev) begin
                  $error("photon_energy_ev: expected %0d, got %0d",
                         exp_r.energy_ev, rsp_photon_energy_ev);
                  fail_count++;
               end
               if (rsp_emit_probability !== exp_r.probability) begin
                  $error("emit_probability: expected %h, got %h",
                         exp_r.probability, rsp_emit_probability);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_photons.size();
   end

endmodule

// File: tb/tb_inner_brems_photon_sampler.sv
`timescale 1ns / 1ps
// Top-level testbench for the inner bremsstrahlung photon sampler: stimulus and verdict.
// Depends on ibps_pkg, the block itself and the tb_ibps_checker scoreboard module.
module tb_inner_brems_photon_sampler;
   import ibps_pkg::*;

   // The limit covers every request as a radiating beta, plus stalls and the
   // hold-off, several times over.
   localparam longint CYCLE_LIMIT = 64'd25_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_is_beta;
   logic [23:0] req_kinetic_energy_ev;
   logic [31:0] req_rand_emit;
   logic [31:0] req_rand_energy;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_photon_emitted;
   logic [23:0] rsp_photon_energy_ev;
   logic [31:0] rsp_emit_probability;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_wdata;

   int     fail_count;
   int     outstanding;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     hold_cycles;
   logic   hold_go;
   longint cycle_count;

   inner_brems_photon_sampler u_dut (.*);

   tb_ibps_checker #(.POINT_COUNT(POINT_COUNT_DEF)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: the run must finish well inside the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side. A requested hold-off keeps stall high for a long stretch so
   // that the block fills up and stalls its request input; otherwise the stall is
   // random at the current idle percentage.
   always @(posedge clock) begin
      if (hold_go) begin
         hold_cycles <= 3000;
         hold_go = 1'b0;
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one request and holds it until the block takes it. The random gap in
   // front of it is where the sender idles.
   task automatic send_request(logic beta, logic [23:0] e_ev, logic [31:0] r_emit,
                               logic [31:0] r_energy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_is_beta <= beta;
      req_kinetic_energy_ev <= e_ev;
      req_rand_emit <= r_emit;
      req_rand_energy <= r_energy;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid and waits until every predicted response has come back, then lets
   // the short-path latency pass so that the block is idle for a register write.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly radiating betas with random content; rand_emit is shrunk by a random
   // shift so that emissions happen often despite small probabilities.
   task automatic random_request();
      int kind;
      kind = $urandom_range(99);
      if (kind < 75)
         send_request(1'b1, 24'($urandom_range(24'hFFFFFF, 20000)),
                      $urandom >> $urandom_range(31), $urandom);
      else if (kind < 85)
         send_request(1'b1, 24'($urandom_range(10300)), $urandom, $urandom);
      else
         send_request(1'b0, 24'($urandom), $urandom, $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_is_beta = 1'b0;
      req_kinetic_energy_ev = '0;
      req_rand_emit = '0;
      req_rand_energy = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_IB_ENABLE;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      hold_go = 1'b0;
      cycle_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings, written explicitly once.
      write_register(CSR_IB_ENABLE, 32'd1);
      write_register(CSR_BIAS, 32'd65536);
      send_request(1'b0, 24'hFFFFFF, 32'd0, 32'd0);              // not a beta
      send_request(1'b1, 24'd0, 32'd0, 32'd0);                   // zero energy
      send_request(1'b1, 24'd10000, 32'd0, 32'd0);               // just under threshold
      send_request(1'b1, 24'd10300, 32'd0, 32'd0);               // just over threshold
      send_request(1'b1, 24'hFFFFFF, 32'd0, 32'd0);              // top energy, first point
      send_request(1'b1, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(1'b1, 24'd1000000, 32'd0, 32'hFFFF_FFFF);     // last point
      send_request(1'b1, 24'd500000, 32'd1, 32'h8000_0000);
      drain_responses();

      // Largest bias saturates the probability; all ones still declines.
      write_register(CSR_BIAS, 32'hFFFF_FFFF);
      send_request(1'b1, 24'd2000000, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(1'b1, 24'd2000000, 32'hFFFF_FFFE, 32'd0);
      drain_responses();
      write_register(CSR_BIAS, 32'd0);
      send_request(1'b1, 24'd1000000, 32'd0, 32'd0);
      drain_responses();
      write_register(CSR_IB_ENABLE, 32'd0);                      // disabled
      send_request(1'b1, 24'd1000000, 32'd0, 32'd0);
      drain_responses();
      write_register(CSR_IB_ENABLE, 32'd1);
      write_register(CSR_BIAS, 32'd65536);

      // Random phase one: sender idles rarely, receiver often. It opens with a
      // long receiver hold-off while quick requests pile up behind it.
      send_idle_pct = 15;
      recv_idle_pct = 61;
      hold_go = 1'b1;
      repeat (6) send_request(1'b0, 24'($urandom), $urandom, $urandom);
      for (int n = 0; n < 30; n++) random_request();
      drain_responses();

      write_register(CSR_BIAS, $urandom_range(32'h0100_0000, 32'h0001_0000));
      send_idle_pct = 61;
      recv_idle_pct = 15;
      for (int n = 0; n < 30; n++) random_request();
      drain_responses();

      write_register(CSR_IB_ENABLE, 32'd1);
      write_register(CSR_BIAS, $urandom);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int n = 0; n < 30; n++) random_request();
      drain_responses();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
